@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/ppd_pkg.sv @@
// Shared types and constants for the polyline point-at-distance block.
package ppd_pkg;
    localparam int MaxPoints = 16;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CoordW = 16;
    localparam int LenW = 17;
    localparam int DistW = 24;
    localparam int CfgW = 5;
    localparam int SqW = 34;
    localparam int ProdW = CoordW + 1 + DistW + 1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_SQ,
        ST_WR_SQRT,
        ST_WR_LEN,
        ST_Q_SUM_RD,
        ST_Q_SUM,
        ST_Q_MOD,
        ST_Q_WALK_RD,
        ST_Q_WALK,
        ST_Q_V1_RD,
        ST_Q_V1,
        ST_Q_V2,
        ST_Q_MULX,
        ST_Q_DIVX,
        ST_Q_MULY,
        ST_Q_DIVY,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [ProdW-1:0]      num;
        logic [DistW-1:0]      den;
    } t_div_req;
endpackage

@@ sv/ppd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module ppd_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/ppd_divu.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
module ppd_divu
    import ppd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [ProdW-1:0]  o_quot,
    output logic [ProdW-1:0]  o_rem
);
    localparam int CntW = $clog2(ProdW + 1);
    logic [ProdW-1:0] r_q, n_q;
    logic [ProdW:0]   r_r, n_r;
    logic [DistW-1:0] r_d;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [ProdW:0]   sh;

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        sh = {r_r[ProdW-1:0], r_q[ProdW-1]};
        if (i_req.start) begin
            n_q = i_req.num;
            n_r = '0;
            n_cnt = CntW'(ProdW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (sh >= {{(ProdW+1-DistW){1'b0}}, r_d}) begin
                n_r = sh - {{(ProdW+1-DistW){1'b0}}, r_d};
                n_q = {r_q[ProdW-2:0], 1'b1};
            end else begin
                n_r = sh;
                n_q = {r_q[ProdW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_req.start) begin
            r_d <= i_req.den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem = r_r[ProdW-1:0];
endmodule

@@ sv/polyline_point_at_distance.sv @@
// Top level: polyline vertex store and point-at-distance query engine.
//  channel | dir | handshake      | word
//  in      | in  | valid / stall  | opcode, index, x, y, distance
//  out     | out | valid / stall  | point x, y, segment, degenerate flag
//  cfg     | in  | valid / ready  | points in use
// Vertex write: WR_RD, WR_SQ and WR_LEN set up, then 17 square-root steps; index 0 ends after WR_RD.
// Query: sum the segment lengths, divide for the wrap-around remainder when the distance
// exceeds the total, walk the segments, read both vertices, then divide for x and for y.
// A degenerate result skips the divides. Reset is synchronous; stores hold nothing
// until written. A stalled result holds in the output register; input waits while busy or while a result is held.
`include "assert_macros.svh"
module polyline_point_at_distance
    import ppd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [IdxW-1:0]           i_vertex_index,
    input  logic signed [CoordW-1:0]  i_vertex_x,
    input  logic signed [CoordW-1:0]  i_vertex_y,
    input  logic [DistW-1:0]          i_query_distance,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [CoordW-1:0]  o_point_x,
    output logic signed [CoordW-1:0]  o_point_y,
    output logic [IdxW-1:0]           o_segment_found,
    output logic                      o_degenerate,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CfgW-1:0]           i_cfg_data
);
    localparam int SqCntW = $clog2(SqW / 2 + 1);

    t_state r_state, n_state;
    logic [CfgW-1:0] r_pts;
    logic [IdxW-1:0] r_segs;

    logic [IdxW-1:0] r_idx, n_idx;
    logic signed [CoordW-1:0] r_wx, r_wy;
    logic [DistW-1:0] r_rem, n_rem;
    logic [DistW-1:0] r_total, n_total;
    logic [IdxW-1:0] r_seg, n_seg;
    logic [LenW-1:0] r_len, n_len;
    logic signed [CoordW-1:0] r_x1, n_x1, r_y1, n_y1;
    logic signed [CoordW:0] r_dx, n_dx, r_dy, n_dy;
    logic [SqW-1:0] r_sqv, n_sqv, r_sqres, n_sqres;
    logic [SqCntW-1:0] r_sqcnt, n_sqcnt;
    logic r_neg, n_neg;
    logic signed [CoordW-1:0] r_px, n_px, r_py, n_py;
    logic [IdxW-1:0] r_oseg, n_oseg;
    logic r_odeg, n_odeg;
    logic r_ovalid, n_ovalid;

    logic vx_we, len_we;
    logic [IdxW-1:0] vx_raddr, len_raddr, len_waddr;
    logic [CoordW-1:0] vx_rdata, vy_rdata;
    logic [LenW-1:0] len_rdata, len_wdata;
    t_div_req div_req;
    logic div_done;
    logic [ProdW-1:0] div_quot, div_rem;

    logic in_acc;
    logic [SqW-1:0] sq_trial, sq_bit;
    logic signed [2*CoordW+1:0] sqx, sqy;
    logic signed [2*CoordW+1:0] mdx, mdy;
    logic [ProdW-1:0] mag;
    logic [LenW-1:0] rcl;
    logic [CfgW-1:0] act_pts;

    ppd_ram #(.Width(CoordW), .Depth(MaxPoints)) u_vx (
        .i_clk(i_clk), .i_we(vx_we), .i_waddr(r_idx), .i_wdata(r_wx),
        .i_raddr(vx_raddr), .o_rdata(vx_rdata));
    ppd_ram #(.Width(CoordW), .Depth(MaxPoints)) u_vy (
        .i_clk(i_clk), .i_we(vx_we), .i_waddr(r_idx), .i_wdata(r_wy),
        .i_raddr(vx_raddr), .o_rdata(vy_rdata));
    ppd_ram #(.Width(LenW), .Depth(MaxPoints)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_raddr(len_raddr), .o_rdata(len_rdata));

    ppd_divu u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_quot), .o_rem(div_rem));

    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign in_acc = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign act_pts = (r_pts < CfgW'(2)) ? CfgW'(2) :
                     (r_pts > CfgW'(MaxPoints)) ? CfgW'(MaxPoints) : r_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts <= CfgW'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pts <= i_cfg_data;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_rem = r_rem;
        n_total = r_total;
        n_seg = r_seg;
        n_len = r_len;
        n_x1 = r_x1; n_y1 = r_y1;
        n_dx = r_dx; n_dy = r_dy;
        n_sqv = r_sqv; n_sqres = r_sqres; n_sqcnt = r_sqcnt;
        n_neg = r_neg;
        n_px = r_px; n_py = r_py; n_oseg = r_oseg; n_odeg = r_odeg;
        n_ovalid = r_ovalid && i_stall;
        vx_we = 1'b0;
        len_we = 1'b0;
        len_waddr = r_idx - 1'b1;
        len_wdata = r_sqres[LenW-1:0];
        vx_raddr = r_idx;
        len_raddr = r_idx;
        div_req = '0;
        sq_bit = SqW'(1) << (2 * (r_sqcnt - 1'b1));
        sq_trial = r_sqres + sq_bit;
        sqx = r_dx * r_dx;
        sqy = r_dy * r_dy;
        mdx = r_dx * $signed({1'b0, r_rem});
        mdy = r_dy * $signed({1'b0, r_rem});
        mag = '0;
        rcl = (r_rem > DistW'(r_len)) ? r_len : r_rem[LenW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = i_vertex_index;
                    n_rem = i_query_distance;
                    if (t_op'(i_opcode) == OP_WRITE) begin
                        vx_we = 1'b0;
                        n_state = ST_WR_RD;
                    end else begin
                        n_idx = '0;
                        n_total = '0;
                        n_state = ST_Q_SUM_RD;
                    end
                end
            end
            ST_WR_RD: begin
                vx_we = 1'b1;
                vx_raddr = r_idx - 1'b1;
                n_state = (r_idx == '0) ? ST_IDLE : ST_WR_SQ;
            end
            ST_WR_SQ: begin
                n_dx = $signed({r_wx[CoordW-1], r_wx}) - $signed({vx_rdata[CoordW-1], vx_rdata});
                n_dy = $signed({r_wy[CoordW-1], r_wy}) - $signed({vy_rdata[CoordW-1], vy_rdata});
                n_state = ST_WR_LEN;
            end
            ST_WR_LEN: begin
                n_sqv = $unsigned(sqx) + $unsigned(sqy);
                n_sqres = '0;
                n_sqcnt = SqCntW'(SqW / 2);
                n_state = ST_WR_SQRT;
            end
            ST_WR_SQRT: begin
                if (r_sqv >= sq_trial) begin
                    n_sqv = r_sqv - sq_trial;
                    n_sqres = (r_sqres >> 1) + sq_bit;
                end else begin
                    n_sqres = r_sqres >> 1;
                end
                n_sqcnt = r_sqcnt - 1'b1;
                if (r_sqcnt == SqCntW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_Q_SUM_RD: begin
                len_raddr = r_idx;
                n_state = ST_Q_SUM;
            end
            ST_Q_SUM: begin
                n_total = r_total + DistW'(len_rdata);
                n_idx = r_idx + 1'b1;
                len_raddr = r_idx + 1'b1;
                if (CfgW'(r_idx) + CfgW'(2) >= act_pts) begin
                    n_state = ST_Q_MOD;
                    if (n_total != '0 && r_rem > n_total) begin
                        div_req.start = 1'b1;
                        div_req.num = ProdW'(r_rem - 1'b1);
                        div_req.den = n_total;
                    end
                end
            end
            ST_Q_MOD: begin
                n_seg = '0;
                n_idx = '0;
                if (r_total == '0) begin
                    n_odeg = 1'b1;
                    n_oseg = '0;
                    vx_raddr = '0;
                    n_state = ST_Q_V1_RD;
                end else if (r_rem > r_total) begin
                    if (div_done) begin
                        n_rem = DistW'(div_rem) + 1'b1;
                        n_state = ST_Q_WALK_RD;
                    end
                end else begin
                    n_state = ST_Q_WALK_RD;
                end
            end
            ST_Q_WALK_RD: begin
                len_raddr = r_seg;
                n_state = ST_Q_WALK;
            end
            ST_Q_WALK: begin
                if (DistW'(len_rdata) < r_rem && (CfgW'(r_idx) + CfgW'(2) < act_pts)) begin
                    n_rem = r_rem - DistW'(len_rdata);
                    n_seg = (CfgW'(r_seg) + CfgW'(2) < act_pts) ? r_seg + 1'b1 : '0;
                    n_idx = r_idx + 1'b1;
                    n_state = ST_Q_WALK_RD;
                end else begin
                    if (DistW'(len_rdata) < r_rem) begin
                        n_rem = r_rem - DistW'(len_rdata);
                        n_seg = (CfgW'(r_seg) + CfgW'(2) < act_pts) ? r_seg + 1'b1 : '0;
                        len_raddr = n_seg;
                        n_state = ST_Q_WALK_RD;
                        n_idx = '1;
                    end else begin
                        n_len = len_rdata;
                        n_odeg = (len_rdata == '0);
                        n_oseg = r_seg;
                        vx_raddr = r_seg;
                        n_state = ST_Q_V1_RD;
                    end
                    if (r_idx == '1) begin
                        n_len = len_rdata;
                        n_odeg = (len_rdata == '0);
                        n_oseg = r_seg;
                        vx_raddr = r_seg;
                        n_state = ST_Q_V1_RD;
                    end
                end
            end
            ST_Q_V1_RD: begin
                vx_raddr = r_oseg;
                n_state = ST_Q_V1;
            end
            ST_Q_V1: begin
                n_x1 = vx_rdata;
                n_y1 = vy_rdata;
                vx_raddr = r_oseg + 1'b1;
                n_state = ST_Q_V2;
            end
            ST_Q_V2: begin
                n_dx = $signed({vx_rdata[CoordW-1], vx_rdata}) - $signed({r_x1[CoordW-1], r_x1});
                n_dy = $signed({vy_rdata[CoordW-1], vy_rdata}) - $signed({r_y1[CoordW-1], r_y1});
                n_rem = DistW'(rcl);
                if (r_odeg) begin
                    n_px = r_x1;
                    n_py = r_y1;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_Q_MULX;
                end
            end
            ST_Q_MULX: begin
                n_neg = mdx < 0;
                mag = n_neg ? ProdW'(-mdx) : ProdW'(mdx);
                div_req.start = 1'b1;
                div_req.num = mag;
                div_req.den = DistW'(r_len);
                n_state = ST_Q_DIVX;
            end
            ST_Q_DIVX: begin
                if (div_done) begin
                    n_px = r_x1 + (r_neg ? -CoordW'(div_quot) : CoordW'(div_quot));
                    n_state = ST_Q_MULY;
                end
            end
            ST_Q_MULY: begin
                n_neg = mdy < 0;
                mag = n_neg ? ProdW'(-mdy) : ProdW'(mdy);
                div_req.start = 1'b1;
                div_req.num = mag;
                div_req.den = DistW'(r_len);
                n_state = ST_Q_DIVY;
            end
            ST_Q_DIVY: begin
                if (div_done) begin
                    n_py = r_y1 + (r_neg ? -CoordW'(div_quot) : CoordW'(div_quot));
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_WR_SQRT && r_sqcnt == SqCntW'(1)) begin
            len_we = 1'b1;
            len_wdata = n_sqres[LenW-1:0];
        end
        if (r_state == ST_IDLE && in_acc && t_op'(i_opcode) == OP_QUERY) begin
            n_odeg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
        if (in_acc) begin
            r_wx <= i_vertex_x;
            r_wy <= i_vertex_y;
        end
        r_idx <= n_idx; r_rem <= n_rem; r_total <= n_total; r_seg <= n_seg;
        r_len <= n_len; r_x1 <= n_x1; r_y1 <= n_y1;
        r_dx <= n_dx; r_dy <= n_dy; r_sqv <= n_sqv; r_sqres <= n_sqres;
        r_sqcnt <= n_sqcnt; r_neg <= n_neg;
        r_px <= n_px; r_py <= n_py; r_oseg <= n_oseg; r_odeg <= n_odeg;
        r_segs <= act_pts[IdxW-1:0] - 1'b1;
    end

    assign o_valid = r_ovalid;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_segment_found = r_oseg;
    assign o_degenerate = r_odeg;

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid,
        "result dropped while stalled")
    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall,
        "input taken while busy")
    `CHK_IMPL(a_seg_range, i_clk, i_rst_n, r_ovalid,
        CfgW'(r_oseg) < act_pts || r_oseg <= r_segs,
        "segment index beyond path")
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the polyline point-at-distance block.
`timescale 1ns / 1ps
module tb;
    import ppd_pkg::*;

    typedef struct {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [IdxW-1:0]          seg;
        logic                     degen;
    } t_point;

    typedef struct {
        t_op                      op;
        logic [IdxW-1:0]          idx;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic [DistW-1:0]         qdist;
        bit                       typed;
        t_point                   want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_opcode = 1'b0;
    logic [IdxW-1:0]           i_vertex_index = '0;
    logic signed [CoordW-1:0]  i_vertex_x = '0;
    logic signed [CoordW-1:0]  i_vertex_y = '0;
    logic [DistW-1:0]          i_query_distance = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [CoordW-1:0]  o_point_x;
    logic signed [CoordW-1:0]  o_point_y;
    logic [IdxW-1:0]           o_segment_found;
    logic                      o_degenerate;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CfgW-1:0]           i_cfg_data = '0;

    polyline_point_at_distance dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [CoordW-1:0] path_x [MaxPoints];
    logic signed [CoordW-1:0] path_y [MaxPoints];
    logic [LenW-1:0]          seg_len [MaxPoints];
    logic [CfgW-1:0]          points_cfg = 5'd2;

    t_point pending_points[$];
    t_row   dir_rows[$];
    int     errors = 0;
    int     points_checked = 0;
    int     words_sent = 0;
    int     degen_seen = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_left = 0;

    function automatic logic [LenW-1:0] floor_root(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 40;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[LenW-1:0];
    endfunction

    function automatic void store_vertex(logic [IdxW-1:0] k, logic signed [CoordW-1:0] x,
                                         logic signed [CoordW-1:0] y);
        longint dx, dy;
        path_x[k] = x;
        path_y[k] = y;
        if (k > 0) begin
            dx = longint'(x) - longint'(path_x[k-1]);
            dy = longint'(y) - longint'(path_y[k-1]);
            seg_len[k-1] = floor_root(dx * dx + dy * dy);
        end
    endfunction

    function automatic t_point point_along(logic [DistW-1:0] qdist);
        t_point p;
        int segs, n, s;
        longint total, rem, len, r;
        n = points_cfg;
        if (n < 2) n = 2;
        if (n > MaxPoints) n = MaxPoints;
        segs = n - 1;
        total = 0;
        for (int i = 0; i < segs; i++) total += seg_len[i];
        p.seg = '0;
        p.degen = 1'b0;
        if (total == 0) begin
            p.degen = 1'b1;
            p.x = path_x[0];
            p.y = path_y[0];
            return p;
        end
        rem = qdist;
        if (rem > total) rem = (rem - 1) % total + 1;
        s = 0;
        for (int i = 0; i < segs; i++) begin
            if (seg_len[s] < rem) begin
                rem -= seg_len[s];
                s = (s + 1 < segs) ? s + 1 : 0;
            end else begin
                break;
            end
        end
        p.seg = s[IdxW-1:0];
        len = seg_len[s];
        if (len == 0) begin
            p.degen = 1'b1;
            p.x = path_x[s];
            p.y = path_y[s];
        end else begin
            r = (rem > len) ? len : rem;
            p.x = CoordW'(longint'(path_x[s])
                + ((longint'(path_x[s+1]) - longint'(path_x[s])) * r) / len);
            p.y = CoordW'(longint'(path_y[s])
                + ((longint'(path_y[s+1]) - longint'(path_y[s])) * r) / len);
        end
        return p;
    endfunction

    task automatic send_word(t_row w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = w.op;
        i_vertex_index = w.idx;
        i_vertex_x = w.x;
        i_vertex_y = w.y;
        i_query_distance = w.qdist;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        if (w.op == OP_WRITE) begin
            store_vertex(w.idx, w.x, w.y);
        end else if (w.typed) begin
            pending_points.push_back(w.want);
        end else begin
            pending_points.push_back(point_along(w.qdist));
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_points_cfg(logic [CfgW-1:0] v);
        drain();
        repeat (200) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        points_cfg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void add_row(t_op op, int k, int x, int y, int d, bit typed,
                                    int px, int py, int ps, int pd);
        t_row w;
        w.op = op;
        w.idx = k[IdxW-1:0];
        w.x = x[CoordW-1:0];
        w.y = y[CoordW-1:0];
        w.qdist = d[DistW-1:0];
        w.typed = typed;
        w.want.x = px[CoordW-1:0];
        w.want.y = py[CoordW-1:0];
        w.want.seg = ps[IdxW-1:0];
        w.want.degen = pd[0];
        dir_rows.push_back(w);
    endfunction

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return $signed(16'($urandom_range(255))) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = pending_points.pop_front();
                points_checked++;
                if (o_degenerate) degen_seen++;
                if (o_point_x !== e.x) begin
                    $error("point_x expected %0d got %0d", e.x, o_point_x);
                    errors++;
                end
                if (o_point_y !== e.y) begin
                    $error("point_y expected %0d got %0d", e.y, o_point_y);
                    errors++;
                end
                if (o_segment_found !== e.seg) begin
                    $error("segment_found expected %0d got %0d", e.seg, o_segment_found);
                    errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate expected %0d got %0d", e.degen, o_degenerate);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row w;
        logic [CfgW-1:0] cfg_list [8];
        longint span;
        int n;

        cfg_list = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd2, 5'd9};

        // zero path, zero distance, full-range distance, rewritten start vertex
        add_row(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 5, 1, 0, 0, 0, 1);
        add_row(OP_QUERY, 0, 0, 0, 24'hFFFFFF, 1, 0, 0, 0, 1);
        add_row(OP_WRITE, 1, 32767, -32768, 0, 0, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 0, -32768, 32767, 0, 0, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 100, 0, 0, 0, 0, 0);
        for (int k = 1; k < MaxPoints; k++)
            add_row(OP_WRITE, k, (k % 2) ? 32767 - k : -32768 + k,
                    (k == 2) ? 32767 - 1 : k * 1000 - 8000, 0, 0, 0, 0, 0, 0);
        add_row(OP_QUERY, 0, 0, 0, 24'h000010, 0, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 17;
        recv_stall_pct = 56;
        foreach (dir_rows[i]) send_word(dir_rows[i]);

        for (int ph = 0; ph < 8; ph++) begin
            write_points_cfg(cfg_list[ph]);
            case (ph * 3 / 8)
                0: begin send_idle_pct = 17; recv_stall_pct = 56; end
                1: begin send_idle_pct = 56; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 1) hold_left = 400;
            n = points_cfg < 2 ? 2 : (points_cfg > MaxPoints ? MaxPoints : points_cfg);
            span = 0;
            for (int i = 0; i < n - 1; i++) span += seg_len[i];
            for (int j = 0; j < 66; j++) begin
                if (ph == 4 && j == 30) drain();
                w.typed = 0;
                w.x = '0;
                w.y = '0;
                w.idx = '0;
                w.qdist = '0;
                if ($urandom_range(99) < 35) begin
                    w.op = OP_WRITE;
                    w.idx = IdxW'($urandom_range(MaxPoints - 1));
                    if (w.idx > 0 && $urandom_range(5) == 0) begin
                        w.x = path_x[w.idx - 1];
                        w.y = path_y[w.idx - 1];
                    end else begin
                        w.x = rand_coord();
                        w.y = rand_coord();
                    end
                end else begin
                    w.op = OP_QUERY;
                    span = 0;
                    for (int i = 0; i < n - 1; i++) span += seg_len[i];
                    case ($urandom_range(4))
                        0: w.qdist = '0;
                        1: w.qdist = 24'hFFFFFF;
                        2: w.qdist = DistW'($urandom);
                        default: w.qdist = DistW'($urandom_range(0, int'(span * 2 + 1)));
                    endcase
                end
                send_word(w);
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        $display("Sent %0d words over 8 path-length settings, checked %0d points",
                 words_sent, points_checked);
        $display("(%0d degenerate), with stalls and idles on both sides.", degen_seen);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ polyline_point_at_distance.f @@
+incdir+sv
sv/ppd_pkg.sv
sv/ppd_ram.sv
sv/ppd_divu.sv
sv/polyline_point_at_distance.sv
tb/sv/tb.sv
